// File: sv/kred_pkg.sv
// Shared types and constants for the keyboard report event differencer.
`timescale 1ns / 1ps

package kred_pkg;

    localparam int CODE_W             = 8;
    localparam int KEY_COUNT          = 6;
    localparam int KEY_W              = 3;
    localparam int MOD_COUNT          = 3;
    localparam int MOD_W              = 2;
    localparam int SLOT_COUNT_DEFAULT = 6;

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_COUNT - 1);
    localparam logic [MOD_W-1:0] LAST_MOD = MOD_W'(MOD_COUNT - 1);

    localparam logic [CODE_W-1:0] CODE_EMPTY = '0;

    // Usage codes reported for the modifiers: ctrl, shift, alt.
    localparam logic [CODE_W-1:0] MOD_CODES [MOD_COUNT] = '{8'd224, 8'd225, 8'd226};

    // Result of the shared compare unit.
    typedef struct packed {
        logic eq;      // operand a equals operand b
        logic b_zero;  // operand b is the empty code
    } cmp_res_t;

endpackage

// File: sv/kred_cmp_unit.sv
// Shared 8-bit compare unit: equality and empty-code test.
`timescale 1ns / 1ps

module kred_cmp_unit
    import kred_pkg::*;
(
    input  logic [CODE_W-1:0] a,
    input  logic [CODE_W-1:0] b,
    output cmp_res_t          res
);

    assign res.eq     = (a == b);
    assign res.b_zero = (b == CODE_EMPTY);

endmodule

// File: sv/kred_slot_store.sv
// Held key slots: one read port, one write port, cleared by reset.
`timescale 1ns / 1ps

module kred_slot_store
    import kred_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [CODE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [CODE_W-1:0] wr_data
);

    logic [CODE_W-1:0] slot_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_reg[k] <= CODE_EMPTY;
            end
        end
        else if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_addr];

endmodule

// File: sv/keyboard_report_key_event_diff.sv
// Top level: keyboard report to key press/release event sequencer.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// -------   ------------------------   ------------------------------------------
// report    start & !busy              left_ctrl/shift/alt_down, usage_0..usage_5
// events    event_strobe (one cycle)   event_code, is_release, last_event
//
// A report's walk covers the modifiers, the slots, one load per report position
// plus the repeat checks against earlier positions, and a final flush. Its length
// is set by the single shared 8-bit comparator, which does one slot or one report
// position per cycle. Reset clears the slots and modifier flags at once; no
// clearing pass. The receiver cannot stall: each event is presented for exactly
// one cycle, and busy falls in the same cycle that the last one is presented.

module keyboard_report_key_event_diff
    import kred_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              left_ctrl_down,
    input  logic              left_shift_down,
    input  logic              left_alt_down,
    input  logic [CODE_W-1:0] usage_0,
    input  logic [CODE_W-1:0] usage_1,
    input  logic [CODE_W-1:0] usage_2,
    input  logic [CODE_W-1:0] usage_3,
    input  logic [CODE_W-1:0] usage_4,
    input  logic [CODE_W-1:0] usage_5,
    output logic              busy,
    output logic              event_strobe,
    output logic [CODE_W-1:0] event_code,
    output logic              is_release,
    output logic              last_event
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,       // walk the three modifiers
        ST_REL_LOAD,  // fetch one held slot
        ST_REL_SCAN,  // look for the held code in the report
        ST_PR_LOAD,   // fetch one report position
        ST_PR_DUP,    // look for the code earlier in the report
        ST_PR_SLOT,   // look for the code among the slots, track a free one
        ST_FLUSH      // send the pending event with the last mark
    } state_t;

    state_t              state_reg, state_next;
    logic [KEY_W-1:0]    key_idx_reg, key_idx_next;
    logic [KEY_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0]   slot_idx_reg, slot_idx_next;
    logic [CODE_W-1:0]   cur_reg, cur_next;
    logic [CODE_W-1:0]   rep_reg [KEY_COUNT];
    logic [CODE_W-1:0]   rep_next [KEY_COUNT];
    logic [MOD_COUNT-1:0] mod_now_reg, mod_now_next;
    logic [MOD_COUNT-1:0] mod_held_reg, mod_held_next;
    logic                free_valid_reg, free_valid_next;
    logic [SLOT_W-1:0]   free_idx_reg, free_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0]   pend_code_reg, pend_code_next;
    logic                pend_rel_reg, pend_rel_next;
    logic                strobe_reg, strobe_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                rel_reg, rel_next;
    logic                last_reg, last_next;

    // Shared compare unit operands.
    logic [KEY_W-1:0]    rep_addr;
    logic [CODE_W-1:0]   rep_rd;
    logic [CODE_W-1:0]   slot_rd;
    logic [CODE_W-1:0]   cmp_b;
    cmp_res_t            cmp;

    // Slot write port.
    logic                slot_wr_en;
    logic [SLOT_W-1:0]   slot_wr_addr;
    logic [CODE_W-1:0]   slot_wr_data;

    // Event requests from the sequencer.
    logic                emit_req;
    logic [CODE_W-1:0]   emit_code;
    logic                emit_rel;
    logic                flush_req;

    logic [MOD_W-1:0]    mod_idx;
    logic [SLOT_W-1:0]   pick_free;

    assign mod_idx  = key_idx_reg[MOD_W-1:0];
    assign rep_addr = (state_reg == ST_PR_DUP) ? scan_idx_reg : key_idx_reg;
    assign rep_rd   = rep_reg[rep_addr];

    // Slots are read where the slot walk points; the report wherever a scan points.
    assign cmp_b = ((state_reg == ST_REL_LOAD) || (state_reg == ST_PR_SLOT)) ? slot_rd
                                                                              : rep_rd;

    kred_cmp_unit u_cmp (
        .a   (cur_reg),
        .b   (cmp_b),
        .res (cmp)
    );

    kred_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (slot_idx_reg),
        .rd_data (slot_rd),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data)
    );

    // Highest free slot seen so far in the press walk, this slot included.
    assign pick_free = cmp.b_zero ? slot_idx_reg : free_idx_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        key_idx_next    = key_idx_reg;
        scan_idx_next   = scan_idx_reg;
        slot_idx_next   = slot_idx_reg;
        cur_next        = cur_reg;
        rep_next        = rep_reg;
        mod_now_next    = mod_now_reg;
        mod_held_next   = mod_held_reg;
        free_valid_next = free_valid_reg;
        free_idx_next   = free_idx_reg;
        slot_wr_en      = 1'b0;
        slot_wr_addr    = slot_idx_reg;
        slot_wr_data    = CODE_EMPTY;
        emit_req        = 1'b0;
        emit_code       = cur_reg;
        emit_rel        = 1'b0;
        flush_req       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Capture the report; the walk reads only these copies.
                    rep_next     = '{usage_0, usage_1, usage_2, usage_3, usage_4, usage_5};
                    mod_now_next = {left_alt_down, left_shift_down, left_ctrl_down};
                    key_idx_next = '0;
                    state_next   = ST_MOD;
                end
            end

            ST_MOD:
            begin
                if (mod_now_reg[mod_idx] != mod_held_reg[mod_idx])
                begin
                    emit_req               = 1'b1;
                    emit_code              = MOD_CODES[mod_idx];
                    emit_rel               = !mod_now_reg[mod_idx];
                    mod_held_next[mod_idx] = mod_now_reg[mod_idx];
                end
                if (mod_idx == LAST_MOD)
                begin
                    slot_idx_next = '0;
                    state_next    = ST_REL_LOAD;
                end
                else
                begin
                    key_idx_next = key_idx_reg + KEY_W'(1);
                end
            end

            ST_REL_LOAD:
            begin
                cur_next     = slot_rd;
                key_idx_next = '0;
                if (!cmp.b_zero)
                begin
                    state_next = ST_REL_SCAN;
                end
                else if (slot_idx_reg == LAST_SLOT)
                begin
                    state_next = ST_PR_LOAD;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + SLOT_W'(1);
                end
            end

            ST_REL_SCAN:
            begin
                if (cmp.eq || (key_idx_reg == LAST_KEY))
                begin
                    if (!cmp.eq)
                    begin
                        // Held code gone from the report: release and empty the slot.
                        emit_req   = 1'b1;
                        emit_rel   = 1'b1;
                        slot_wr_en = 1'b1;
                    end
                    key_idx_next = '0;
                    if (slot_idx_reg == LAST_SLOT)
                    begin
                        state_next = ST_PR_LOAD;
                    end
                    else
                    begin
                        slot_idx_next = slot_idx_reg + SLOT_W'(1);
                        state_next    = ST_REL_LOAD;
                    end
                end
                else
                begin
                    key_idx_next = key_idx_reg + KEY_W'(1);
                end
            end

            ST_PR_LOAD:
            begin
                cur_next        = rep_rd;
                scan_idx_next   = '0;
                slot_idx_next   = '0;
                free_valid_next = 1'b0;
                if (cmp.b_zero)
                begin
                    if (key_idx_reg == LAST_KEY)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        key_idx_next = key_idx_reg + KEY_W'(1);
                    end
                end
                else if (key_idx_reg == '0)
                begin
                    state_next = ST_PR_SLOT;
                end
                else
                begin
                    state_next = ST_PR_DUP;
                end
            end

            ST_PR_DUP:
            begin
                if (cmp.eq)
                begin
                    // Repeat within the report: drop it.
                    if (key_idx_reg == LAST_KEY)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        key_idx_next = key_idx_reg + KEY_W'(1);
                        state_next   = ST_PR_LOAD;
                    end
                end
                else if ((scan_idx_reg + KEY_W'(1)) == key_idx_reg)
                begin
                    state_next = ST_PR_SLOT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + KEY_W'(1);
                end
            end

            ST_PR_SLOT:
            begin
                if (cmp.eq || (slot_idx_reg == LAST_SLOT))
                begin
                    if (!cmp.eq)
                    begin
                        // New key: press it, store it if a slot was free.
                        emit_req     = 1'b1;
                        slot_wr_en   = cmp.b_zero || free_valid_reg;
                        slot_wr_addr = pick_free;
                        slot_wr_data = cur_reg;
                    end
                    if (key_idx_reg == LAST_KEY)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        key_idx_next = key_idx_reg + KEY_W'(1);
                        state_next   = ST_PR_LOAD;
                    end
                end
                else
                begin
                    if (cmp.b_zero)
                    begin
                        free_valid_next = 1'b1;
                        free_idx_next   = slot_idx_reg;
                    end
                    slot_idx_next = slot_idx_reg + SLOT_W'(1);
                end
            end

            ST_FLUSH:
            begin
                flush_req  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event output: hold one event back so the final one can carry the last mark.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        pend_rel_next   = pend_rel_reg;
        strobe_next     = 1'b0;
        code_next       = code_reg;
        rel_next        = rel_reg;
        last_next       = 1'b0;

        if (emit_req)
        begin
            strobe_next     = pend_valid_reg;
            code_next       = pend_code_reg;
            rel_next        = pend_rel_reg;
            pend_valid_next = 1'b1;
            pend_code_next  = emit_code;
            pend_rel_next   = emit_rel;
        end
        else if (flush_req)
        begin
            strobe_next     = pend_valid_reg;
            code_next       = pend_code_reg;
            rel_next        = pend_rel_reg;
            last_next       = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            slot_idx_reg   <= '0;
            cur_reg        <= CODE_EMPTY;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                rep_reg[k] <= CODE_EMPTY;
            end
            mod_now_reg    <= '0;
            mod_held_reg   <= '0;
            free_valid_reg <= 1'b0;
            free_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_code_reg  <= CODE_EMPTY;
            pend_rel_reg   <= 1'b0;
            strobe_reg     <= 1'b0;
            code_reg       <= CODE_EMPTY;
            rel_reg        <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            key_idx_reg    <= key_idx_next;
            scan_idx_reg   <= scan_idx_next;
            slot_idx_reg   <= slot_idx_next;
            cur_reg        <= cur_next;
            rep_reg        <= rep_next;
            mod_now_reg    <= mod_now_next;
            mod_held_reg   <= mod_held_next;
            free_valid_reg <= free_valid_next;
            free_idx_reg   <= free_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_code_reg  <= pend_code_next;
            pend_rel_reg   <= pend_rel_next;
            strobe_reg     <= strobe_next;
            code_reg       <= code_next;
            rel_reg        <= rel_next;
            last_reg       <= last_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign event_strobe = strobe_reg;
    assign event_code   = code_reg;
    assign is_release   = rel_reg;
    assign last_event   = last_reg;

    // An accepted report always starts a walk.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("report transfer did not start a walk");

    // The final event of a report goes out exactly as the block turns idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        event_strobe && last_event |-> !busy)
        else $error("last event while still busy");

    // Any other event is mid-walk.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        event_strobe && !last_event |-> busy)
        else $error("non-final event after walk ended");

    // No event is ever sent without a walk behind it.
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        event_strobe |-> $past(busy))
        else $error("event transfer without a report in progress");

endmodule

// File: test/keyboard_report_key_event_diff_test.sv
// Self-checking testbench for the keyboard report key event differencer.
`timescale 1ns / 1ps

module keyboard_report_key_event_diff_test
    import kred_pkg::*;
();

    localparam int SLOTS        = SLOT_COUNT_DEFAULT;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 260;
    // Drain well past the longest possible report walk.
    localparam int DRAIN_CYCLES = 130;
    // Roughly 290 reports, each at its longest walk plus the longest gap, taken several times over.
    localparam int LIMIT_CYCLES = 250000;

    typedef logic [KEY_COUNT-1:0][CODE_W-1:0] key_set_t;
    typedef logic [MOD_COUNT-1:0]             mod_set_t;  // bit 0 ctrl, 1 shift, 2 alt

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              release_n_press;
        logic              last;
    } key_event_t;

    // Tracks the pressed-key state of the block and the events each report
    // must produce; compares every strobed event against the oldest one.
    class key_event_board;
        key_event_t        due_events [$];
        logic [CODE_W-1:0] slots [SLOTS];
        mod_set_t          mods_held;
        int                mismatches;

        function new();
            foreach (slots[s]) slots[s] = CODE_EMPTY;
            mods_held  = '0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return due_events.size();
        endfunction

        // Advance the mirrored state by one accepted report and queue its events.
        function void note_report(mod_set_t mods, key_set_t keys);
            key_event_t        ev;
            int                first_new;
            int                free_slot;
            logic [CODE_W-1:0] code;
            bit                present;
            bit                held;
            bit                repeated;

            first_new = due_events.size();

            // Modifier changes lead, in ctrl, shift, alt order.
            for (int m = 0; m < MOD_COUNT; m++)
            begin
                if (mods[m] != mods_held[m])
                begin
                    ev = '{code: MOD_CODES[m], release_n_press: !mods[m], last: 1'b0};
                    due_events.push_back(ev);
                    mods_held[m] = mods[m];
                end
            end

            // Release held codes that are gone from the report, in slot order.
            for (int s = 0; s < SLOTS; s++)
            begin
                code = slots[s];
                if (code == CODE_EMPTY) continue;
                present = 1'b0;
                for (int k = 0; k < KEY_COUNT; k++)
                    if (keys[k] == code) present = 1'b1;
                if (!present)
                begin
                    ev = '{code: code, release_n_press: 1'b1, last: 1'b0};
                    due_events.push_back(ev);
                    slots[s] = CODE_EMPTY;
                end
            end

            // Press new codes in report order; a repeat within the report is dropped.
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                code = keys[k];
                if (code == CODE_EMPTY) continue;
                repeated = 1'b0;
                for (int p = 0; p < k; p++)
                    if (keys[p] == code) repeated = 1'b1;
                if (repeated) continue;
                // Take the highest empty slot seen before a matching slot.
                held      = 1'b0;
                free_slot = -1;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!held)
                    begin
                        if (slots[s] == CODE_EMPTY) free_slot = s;
                        if (slots[s] == code)
                        begin
                            held      = 1'b1;
                            free_slot = -1;
                        end
                    end
                end
                if (free_slot >= 0) slots[free_slot] = code;
                if (!held)
                begin
                    ev = '{code: code, release_n_press: 1'b0, last: 1'b0};
                    due_events.push_back(ev);
                end
            end

            // Mark the final event of this report.
            if (due_events.size() > first_new)
            begin
                ev      = due_events.pop_back();
                ev.last = 1'b1;
                due_events.push_back(ev);
            end
        endfunction

        task flag_mismatch(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_event(logic [CODE_W-1:0] code, logic rel, logic last);
            key_event_t want;
            if (due_events.size() == 0)
            begin
                flag_mismatch($sformatf("event code %0d rel %0b last %0b with none due",
                                        code, rel, last));
            end
            else
            begin
                want = due_events.pop_front();
                if (code !== want.code)
                    flag_mismatch($sformatf("event_code got %0d want %0d", code, want.code));
                if (rel !== want.release_n_press)
                    flag_mismatch($sformatf("is_release got %0b want %0b on code %0d",
                                            rel, want.release_n_press, want.code));
                if (last !== want.last)
                    flag_mismatch($sformatf("last_event got %0b want %0b on code %0d",
                                            last, want.last, want.code));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              left_ctrl_down;
    logic              left_shift_down;
    logic              left_alt_down;
    logic [CODE_W-1:0] usage_0;
    logic [CODE_W-1:0] usage_1;
    logic [CODE_W-1:0] usage_2;
    logic [CODE_W-1:0] usage_3;
    logic [CODE_W-1:0] usage_4;
    logic [CODE_W-1:0] usage_5;
    logic              busy;
    logic              event_strobe;
    logic [CODE_W-1:0] event_code;
    logic              is_release;
    logic              last_event;

    key_event_board board;
    int             cycle_count;
    int             burst_left;
    mod_set_t       cur_mods;
    key_set_t       cur_keys;

    keyboard_report_key_event_diff #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .left_ctrl_down(left_ctrl_down),
        .left_shift_down(left_shift_down),
        .left_alt_down(left_alt_down),
        .usage_0(usage_0),
        .usage_1(usage_1),
        .usage_2(usage_2),
        .usage_3(usage_3),
        .usage_4(usage_4),
        .usage_5(usage_5),
        .busy(busy),
        .event_strobe(event_strobe),
        .event_code(event_code),
        .is_release(is_release),
        .last_event(last_event)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver cannot stall: sample every strobed event at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && event_strobe === 1'b1)
            board.check_event(event_code, is_release, last_event);
    end

    // Hold a report on the ports with start high until the block takes it,
    // then record it. Must be called at a rising edge; returns at the
    // edge of the transfer.
    task automatic send_report(input mod_set_t mods, input key_set_t keys);
        start           <= 1'b1;
        left_ctrl_down  <= mods[0];
        left_shift_down <= mods[1];
        left_alt_down   <= mods[2];
        usage_0         <= keys[0];
        usage_1         <= keys[1];
        usage_2         <= keys[2];
        usage_3         <= keys[3];
        usage_4         <= keys[4];
        usage_5         <= keys[5];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_report(mods, keys);
        cur_mods = mods;
        cur_keys = keys;
    endtask

    // Send in bursts: back to back inside a burst, a random gap between bursts.
    // Only drop start when a real gap follows, so it never toggles in one step.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(15, 40);
            else
                burst_left = $urandom_range(0, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic directed(input mod_set_t mods,
                            input logic [CODE_W-1:0] k0, input logic [CODE_W-1:0] k1,
                            input logic [CODE_W-1:0] k2, input logic [CODE_W-1:0] k3,
                            input logic [CODE_W-1:0] k4, input logic [CODE_W-1:0] k5);
        key_set_t keys;
        keys[0] = k0;
        keys[1] = k1;
        keys[2] = k2;
        keys[3] = k3;
        keys[4] = k4;
        keys[5] = k5;
        send_report(mods, keys);
        pace();
    endtask

    // Favor a small pool of codes so matches and repeats happen often.
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CODE_EMPTY;
        else if (r < 80)
            return CODE_W'($urandom_range(4, 11));
        else
            return CODE_W'($urandom_range(0, 255));
    endfunction

    // Build the next random report, mostly as a small edit of the last one.
    task automatic send_random_report();
        mod_set_t mods;
        key_set_t keys;
        int       r;
        int       a;
        int       b;
        logic [CODE_W-1:0] tmp;

        mods = cur_mods;
        keys = cur_keys;
        r    = $urandom_range(0, 99);
        if (r < 55)
        begin
            // Typing: change one or two positions, maybe a modifier.
            repeat ($urandom_range(1, 2))
            begin
                a = $urandom_range(0, KEY_COUNT - 1);
                if ($urandom_range(0, 4) == 0)
                    keys[a] = keys[$urandom_range(0, KEY_COUNT - 1)];
                else
                    keys[a] = pick_code();
            end
            if ($urandom_range(0, 3) == 0)
                mods[$urandom_range(0, MOD_COUNT - 1)] ^= 1'b1;
        end
        else if (r < 70)
        begin
            // Same keys in another order.
            a       = $urandom_range(0, KEY_COUNT - 1);
            b       = $urandom_range(0, KEY_COUNT - 1);
            tmp     = keys[a];
            keys[a] = keys[b];
            keys[b] = tmp;
        end
        else if (r < 85)
        begin
            for (int k = 0; k < KEY_COUNT; k++) keys[k] = pick_code();
            mods = mod_set_t'($urandom_range(0, 7));
        end
        else
        begin
            // Noise across the whole code range.
            for (int k = 0; k < KEY_COUNT; k++) keys[k] = CODE_W'($urandom_range(0, 255));
            mods = mod_set_t'($urandom_range(0, 7));
        end
        send_report(mods, keys);
        pace();
    endtask

    initial
    begin
        // Drive every input to a known value from time zero.
        rst_n           = 1'b0;
        start           = 1'b0;
        left_ctrl_down  = 1'b0;
        left_shift_down = 1'b0;
        left_alt_down   = 1'b0;
        usage_0         = '0;
        usage_1         = '0;
        usage_2         = '0;
        usage_3         = '0;
        usage_4         = '0;
        usage_5         = '0;
        cycle_count     = 0;
        burst_left      = 0;
        cur_mods        = '0;
        cur_keys        = '0;
        board           = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty report against the reset state: nothing changes, no events.
        directed(3'b000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        directed(3'b001, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Shift and alt press, then fill all six slots.
        directed(3'b111, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        // Identical report: no events.
        directed(3'b111, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        // Same keys reversed, all modifiers released: only modifier events.
        directed(3'b000, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4);
        // Partial replace: releases in slot order, then presses in report order.
        directed(3'b000, 8'd9, 8'd10, 8'd0, 8'd11, 8'd0, 8'd4);
        // Repeated code within one report is pressed once.
        directed(3'b010, 8'd12, 8'd12, 8'd12, 8'd9, 8'd9, 8'd0);
        // Repeat of a code that is already held gives nothing.
        directed(3'b010, 8'd9, 8'd12, 8'd9, 8'd12, 8'd0, 8'd0);
        directed(3'b111, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        // Extremes, including codes equal to the modifier codes.
        directed(3'b101, 8'd1, 8'd255, 8'd224, 8'd225, 8'd226, 8'd128);
        directed(3'b000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        directed(3'b000, 8'd20, 8'd0, 8'd20, 8'd0, 8'd20, 8'd0);
        directed(3'b000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd20);
        directed(3'b000, 8'd21, 8'd20, 8'd22, 8'd23, 8'd24, 8'd25);
        // Full replacement of all six held codes: six releases, six presses.
        directed(3'b111, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31);
        // Modifiers one at a time.
        directed(3'b010, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31);
        directed(3'b100, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31);
        directed(3'b001, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31);
        // Alternating bit patterns on every usage port.
        directed(3'b000, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
        directed(3'b111, 8'h55, 8'haa, 8'h0f, 8'hf0, 8'h33, 8'hcc);
        // Free slots scattered: release slots 0, 2 and 5, then refill.
        directed(3'b000, 8'h55, 8'd0, 8'h0f, 8'd0, 8'h33, 8'd0);
        directed(3'b000, 8'd40, 8'h55, 8'd41, 8'h0f, 8'd42, 8'h33);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_random_report();

        // Stop sending, wait for every due event, then watch for strays.
        start <= 1'b0;
        while (board.pending_count() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
